### rtl/core/rgcb_pkg.sv
// Package with the types, register indexes and arithmetic helpers of the glyph coverage blender.
package rgcb_pkg;

    localparam int CHAN_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int CURVE_AW   = 8;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FORE_RGBA = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_RGBA = 1'b1;

    localparam logic [CHAN_W-1:0] FULL = 8'd255;

    localparam logic [CFG_DATA_W-1:0] FORE_RESET = 32'hFFFF_FFFF;
    localparam logic [CFG_DATA_W-1:0] BACK_RESET = 32'h0000_0000;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] a;
    } t_rgba;

    // Truncating division by 255, exact for every value up to 255 * 255.
    function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return s[15:8];
    endfunction

    // Weighted mix: a weighted by wa, b weighted by 255 - wa.
    function automatic logic [CHAN_W-1:0] mix(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] wa,
                                              input logic [CHAN_W-1:0] b);
        logic [15:0] pa;
        logic [15:0] pb;
        pa = {8'd0, a} * {8'd0, wa};
        pb = {8'd0, b} * {8'd0, FULL - wa};
        return div255(pa + pb);
    endfunction

    // Alpha of one layer over another.
    function automatic logic [CHAN_W-1:0] over_alpha(input logic [CHAN_W-1:0] a,
                                                     input logic [CHAN_W-1:0] b);
        logic [15:0] p;
        p = {8'd0, FULL - a} * {8'd0, FULL - b};
        return FULL - div255(p);
    endfunction

endpackage

### rtl/core/rgcb_curve.sv
// Opacity curve memory with one write port and one registered read port.
module rgcb_curve (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [rgcb_pkg::CURVE_AW-1:0]  i_waddr,
    input  logic [rgcb_pkg::CHAN_W-1:0]    i_wdata,
    input  logic                           i_re,
    input  logic [rgcb_pkg::CURVE_AW-1:0]  i_raddr,
    output logic [rgcb_pkg::CHAN_W-1:0]    o_rdata
);
    import rgcb_pkg::*;

    logic [CHAN_W-1:0] r_mem [2**CURVE_AW];
    logic [CHAN_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/rgba_glyph_coverage_blend_top.sv
// Top level of the glyph coverage blender: five-stage pixel pipeline and configuration registers.
//
// The slave stream carries one item per transfer. tuser is the function flag: 0 blends one
// pixel, 1 writes one opacity curve entry. A blend transfer produces one master transfer with
// the new pixel and, in tuser, the write flag; a table write produces none and updates the
// curve at its own transfer, so a blend in the very next cycle already sees the new entry.
// Foreground and background colors are written through the configuration port; the user must
// write them only while the pipeline is empty, which the block itself does not enforce.
// A blend passes from the slave transfer to the result on the master side through a curve
// read stage, then four stages of one multiply pair and divide by 255 each.
// Throughput is one item per cycle while the master side takes results; the memory read port and
// the per-stage multipliers set it. Each stage holds its item while the stage after it is full
// and stalled, so a stall on the master side fills the empty stages first and then lowers
// s_axis_tready; nothing is lost or repeated.
// Reset clears the stage valid bits and loads the foreground with opaque white and the
// background with transparent black. The curve memory is not cleared; an entry must be written
// before a blend reads it.
module rgba_glyph_coverage_blend_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // coverage, dest_red, dest_green, dest_blue, dest_alpha, entry_index, entry_value
    input  logic [rgcb_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // func
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // new_red, new_green, new_blue, new_alpha
    output logic [rgcb_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // write_pixel
    output logic                              m_axis_tuser,
    input  logic                              i_cfg_we,
    input  logic [rgcb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rgcb_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import rgcb_pkg::*;

    t_rgba r_fore;
    t_rgba r_back;

    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;
    logic w_accept;

    logic [CHAN_W-1:0]   w_cov;
    t_rgba               w_in_d;
    logic [CURVE_AW-1:0] w_widx;
    logic [CHAN_W-1:0]   w_wval;
    logic [CHAN_W-1:0]   w_curve;

    logic  r_s1_v;
    t_rgba r_s1_d;

    logic              r_s2_v;
    t_rgba             r_s2_d;
    logic [CHAN_W-1:0] r_s2_o;
    t_rgba             r_s2_bb;
    t_rgba             r_s2_fb;
    t_rgba             r_s2_op;
    t_rgba             n_s2_bb;
    t_rgba             n_s2_fb;
    t_rgba             n_s2_op;

    logic  r_s3_v;
    t_rgba r_s3_d;
    t_rgba r_s3_op;
    t_rgba r_s3_cu;
    t_rgba n_s3_cu;

    logic  r_s4_v;
    t_rgba r_s4_d;
    t_rgba r_s4_op;
    t_rgba r_s4_cu;
    t_rgba r_s4_bd;
    t_rgba n_s4_bd;

    logic  r_s5_v;
    t_rgba r_s5_res;
    logic  r_s5_wr;
    t_rgba n_s5_res;
    logic  n_s5_wr;

    assign w_cov    = s_axis_tdata[7:0];
    assign w_in_d.r = s_axis_tdata[15:8];
    assign w_in_d.g = s_axis_tdata[23:16];
    assign w_in_d.b = s_axis_tdata[31:24];
    assign w_in_d.a = s_axis_tdata[39:32];
    assign w_widx   = s_axis_tdata[47:40];
    assign w_wval   = s_axis_tdata[55:48];

    assign w_rdy5 = !r_s5_v || m_axis_tready;
    assign w_rdy4 = !r_s4_v || w_rdy5;
    assign w_rdy3 = !r_s3_v || w_rdy4;
    assign w_rdy2 = !r_s2_v || w_rdy3;
    assign w_rdy1 = !r_s1_v || w_rdy2;

    assign s_axis_tready = w_rdy1;
    assign w_accept      = s_axis_tvalid && w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fore <= FORE_RESET;
            r_back <= BACK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FORE_RGBA: r_fore <= i_cfg_wdata;
                REG_BACK_RGBA: r_back <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    rgcb_curve u_curve (
        .i_clk   (i_clk),
        .i_we    (w_accept && s_axis_tuser),
        .i_waddr (w_widx),
        .i_wdata (w_wval),
        .i_re    (w_rdy1),
        .i_raddr (w_cov),
        .o_rdata (w_curve)
    );

    always_comb begin
        n_s2_bb.r = mix(r_back.r, r_back.a, r_s1_d.r);
        n_s2_bb.g = mix(r_back.g, r_back.a, r_s1_d.g);
        n_s2_bb.b = mix(r_back.b, r_back.a, r_s1_d.b);
        n_s2_bb.a = over_alpha(r_back.a, r_s1_d.a);
        n_s2_fb.r = mix(r_fore.r, r_fore.a, r_s1_d.r);
        n_s2_fb.g = mix(r_fore.g, r_fore.a, r_s1_d.g);
        n_s2_fb.b = mix(r_fore.b, r_fore.a, r_s1_d.b);
        n_s2_fb.a = over_alpha(r_fore.a, r_s1_d.a);
        n_s2_op.r = mix(r_fore.r, w_curve, r_back.r);
        n_s2_op.g = mix(r_fore.g, w_curve, r_back.g);
        n_s2_op.b = mix(r_fore.b, w_curve, r_back.b);
        n_s2_op.a = FULL;
    end

    always_comb begin
        n_s3_cu.r = mix(r_s2_fb.r, r_s2_o, r_s2_bb.r);
        n_s3_cu.g = mix(r_s2_fb.g, r_s2_o, r_s2_bb.g);
        n_s3_cu.b = mix(r_s2_fb.b, r_s2_o, r_s2_bb.b);
        n_s3_cu.a = mix(r_s2_fb.a, r_s2_o, r_s2_bb.a);
    end

    always_comb begin
        n_s4_bd.r = mix(r_s3_d.r, r_s3_d.a, r_s3_cu.r);
        n_s4_bd.g = mix(r_s3_d.g, r_s3_d.a, r_s3_cu.g);
        n_s4_bd.b = mix(r_s3_d.b, r_s3_d.a, r_s3_cu.b);
        n_s4_bd.a = over_alpha(r_s3_d.a, r_s3_cu.a);
    end

    always_comb begin
        n_s5_wr = 1'b1;
        if (r_fore.a == FULL && r_back.a == FULL) begin
            n_s5_res = r_s4_op;
        end else if (r_fore.a == '0 && r_back.a == '0) begin
            n_s5_res = r_s4_d;
            n_s5_wr  = 1'b0;
        end else begin
            n_s5_res.r = mix(r_s4_cu.r, r_s4_cu.a, r_s4_bd.r);
            n_s5_res.g = mix(r_s4_cu.g, r_s4_cu.a, r_s4_bd.g);
            n_s5_res.b = mix(r_s4_cu.b, r_s4_cu.a, r_s4_bd.b);
            n_s5_res.a = r_s4_bd.a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_s1_v <= s_axis_tvalid && !s_axis_tuser;
            end
            if (w_rdy2) begin
                r_s2_v <= r_s1_v;
            end
            if (w_rdy3) begin
                r_s3_v <= r_s2_v;
            end
            if (w_rdy4) begin
                r_s4_v <= r_s3_v;
            end
            if (w_rdy5) begin
                r_s5_v <= r_s4_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1_d <= w_in_d;
        end
        if (w_rdy2) begin
            r_s2_d  <= r_s1_d;
            r_s2_o  <= w_curve;
            r_s2_bb <= n_s2_bb;
            r_s2_fb <= n_s2_fb;
            r_s2_op <= n_s2_op;
        end
        if (w_rdy3) begin
            r_s3_d  <= r_s2_d;
            r_s3_op <= r_s2_op;
            r_s3_cu <= n_s3_cu;
        end
        if (w_rdy4) begin
            r_s4_d  <= r_s3_d;
            r_s4_op <= r_s3_op;
            r_s4_cu <= r_s3_cu;
            r_s4_bd <= n_s4_bd;
        end
        if (w_rdy5) begin
            r_s5_res <= n_s5_res;
            r_s5_wr  <= n_s5_wr;
        end
    end

    assign m_axis_tvalid = r_s5_v;
    assign m_axis_tdata  = {r_s5_res.a, r_s5_res.b, r_s5_res.g, r_s5_res.r};
    assign m_axis_tuser  = r_s5_wr;

endmodule
